>>> design/assert_macros.svh
// Assertion helpers for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled during reset.
`define CHECK_IMPLY(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that is also live during reset.
`define CHECK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/hmt_pkg.sv
package hmt_pkg;

   localparam int unsigned WindowSide = 3;
   localparam int unsigned CellCount  = WindowSide * WindowSide;
   localparam int unsigned CondCount  = 66;
   localparam int unsigned UncCount   = 87;
   localparam int unsigned UncStEnd   = 69;
   localparam int unsigned UncSkBegin = 37;

   typedef enum logic [1:0] {
      MODE_SHRINK = 2'd0,
      MODE_THIN   = 2'd1,
      MODE_SKEL   = 2'd2,
      MODE_ALT    = 2'd3
   } mode_type;

   localparam logic CSR_ADDR_MODE = 1'b0;

   typedef logic [8:0] cell_type;

   // Tables are written in reading order: leftmost digit is cell 0 (MSB of the
   // literal), so a neighborhood is flipped before it is compared.
   localparam cell_type AllCare = 9'b111111111;

   // Conditional patterns.
   localparam cell_type CondTab [CondCount] = '{
      9'b001010000, 9'b100010000, 9'b000010100, 9'b000010001,
      9'b000011000, 9'b010010000, 9'b000110000, 9'b000010010,
      9'b001011000, 9'b011010000, 9'b110010000, 9'b100110000,
      9'b000110100, 9'b000010110, 9'b000010011, 9'b000011001,
      9'b010011000, 9'b010110000, 9'b000110010, 9'b000011010,
      9'b001011001, 9'b111010000, 9'b100110100, 9'b000010111,
      9'b110011000, 9'b010011001, 9'b011110000, 9'b001011010,
      9'b011011000, 9'b110110000, 9'b000110110, 9'b000011011,
      9'b110011001, 9'b011110100,
      9'b111011000, 9'b011011001, 9'b111110000, 9'b110110100,
      9'b100110110, 9'b000110111, 9'b000011111, 9'b001011011,
      9'b111011001, 9'b111110100, 9'b100110111, 9'b001011111,
      9'b011011011, 9'b111111000, 9'b110110110, 9'b000111111,
      9'b111011011, 9'b011011111, 9'b111111100, 9'b111111001,
      9'b111110110, 9'b110110111, 9'b100111111, 9'b001111111,
      9'b111011111, 9'b111111101, 9'b111110111, 9'b101111111,
      9'b111111011, 9'b111111110, 9'b110111111, 9'b011111111
   };

   // Unconditional masks: required ones, and which cells are cared about.
   // 0..36 shrink/thin only, 37..68 shared, 69..86 skeleton only.
   localparam cell_type UncOne [UncCount] = '{
      9'b001010000, 9'b100010000, 9'b000010010, 9'b000011000,
      9'b001011000, 9'b011010000, 9'b110010000, 9'b100110000,
      9'b000110100, 9'b000010110, 9'b000010011, 9'b000011001,
      9'b011110000, 9'b110011000, 9'b010011001, 9'b001011010,
      9'b011010100, 9'b001011100, 9'b011011100, 9'b110010001,
      9'b100110001, 9'b110110001, 9'b001110100, 9'b001010110,
      9'b001110110, 9'b100011001, 9'b100010011, 9'b100011011,
      9'b110110000,
      9'b010111000, 9'b010111000, 9'b000111010, 9'b000111010,
      9'b010110010, 9'b010110010, 9'b010011010, 9'b010011010,
      9'b101010100, 9'b101010010, 9'b101010001, 9'b101010011,
      9'b101010110, 9'b101010101, 9'b101010111,
      9'b101010100, 9'b100011100, 9'b100010101, 9'b100011101,
      9'b101010101, 9'b101011100, 9'b101011101,
      9'b100010101, 9'b010010101, 9'b001010101, 9'b011010101,
      9'b101010101, 9'b110010101, 9'b111010101,
      9'b101010001, 9'b001110001, 9'b001010101, 9'b001110101,
      9'b101010101, 9'b101110001, 9'b101110101,
      9'b010011100, 9'b010110001, 9'b001110010, 9'b100011010,
      9'b000010001, 9'b000010100, 9'b001010000, 9'b100010000,
      9'b000010010, 9'b000011000, 9'b000110000, 9'b010010000,
      9'b010011000, 9'b010110000, 9'b000011010, 9'b000110010,
      9'b110110000, 9'b000011011,
      9'b010111000, 9'b010110010, 9'b000111010, 9'b010011010
   };

   localparam cell_type UncCare [UncCount] = '{
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      9'b110110000,
      9'b011111011, 9'b110111110, 9'b110111110, 9'b011111011,
      9'b010111111, 9'b111111010, 9'b111111010, 9'b010111111,
      9'b101010111, 9'b101010111, 9'b101010111, 9'b101010111,
      9'b101010111, 9'b101010111, 9'b101010111,
      9'b101011101, 9'b101011101, 9'b101011101, 9'b101011101,
      9'b101011101, 9'b101011101, 9'b101011101,
      9'b111010101, 9'b111010101, 9'b111010101, 9'b111010101,
      9'b111010101, 9'b111010101, 9'b111010101,
      9'b101110101, 9'b101110101, 9'b101110101, 9'b101110101,
      9'b101110101, 9'b101110101, 9'b101110101,
      9'b011111110, 9'b110111011, 9'b011111110, 9'b110111011,
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      AllCare, AllCare, AllCare, AllCare,
      9'b110110000, 9'b000011011,
      9'b010111000, 9'b010110010, 9'b000111010, 9'b010111010
   };

   function automatic cell_type flip(input cell_type x);
      cell_type r;
      for (int i = 0; i < CellCount; i++) r[i] = x[CellCount-1-i];
      return r;
   endfunction

   function automatic logic cond_in_mode(input int unsigned k, input logic [1:0] m);
      logic r;
      case (m)
         MODE_THIN: r = (k >= 16) && (k <= 61);
         MODE_SKEL: r = ((k >= 16) && (k <= 23)) || (k >= 34);
         default:   r = (k <= 15) || ((k >= 20) && (k <= 61));
      endcase
      return r;
   endfunction

   // Any conditional pattern of the mode equals the 3x3 neighborhood.
   function automatic logic cond_mark(input cell_type n, input logic [1:0] m);
      logic     hit;
      cell_type f;
      hit = 1'b0;
      f   = flip(n);
      for (int k = 0; k < CondCount; k++)
         if (cond_in_mode(k, m) && (f == CondTab[k])) hit = 1'b1;
      return hit;
   endfunction

   function automatic logic unc_hit(input cell_type marks, input logic [1:0] m);
      logic     hit;
      cell_type f;
      hit = 1'b0;
      f   = flip(marks);
      for (int k = 0; k < UncCount; k++) begin
         if ((m == MODE_SKEL) ? (k >= UncSkBegin) : (k < UncStEnd))
            if (((f ^ UncOne[k]) & UncCare[k]) == '0) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

>>> design/hit_miss_thinning_pixel_core.sv
// Hit-or-miss shrink / thin / skeletonize, one pass for one pixel.
// Input channel: drive req_window (5x5 neighborhood, bit row*5+col, center bit 12)
// and req_outside_mask (3x3 mark positions lying outside the image), pulse start.
// busy is always low, so an item is accepted at every edge with start high.
// Result channel: rsp_valid strobes for one cycle, with rsp_new_pixel,
// rsp_centre_marked and rsp_changed. Each item passes the input register, then
// the result register; throughput 1 item per cycle; the pattern-matching logic
// sits between the two registers.
// The receiver cannot stall; every result must be taken in its strobe cycle.
// CSR: APB write of register 0 (mode) at byte address 0; pready is tied high.
// Mode 0 shrink, 1 thin, 2 skeletonize, 3 behaves as shrink.
// Reset (synchronous, active high) clears mode to shrink and drops any
// in-flight item.
`include "assert_macros.svh"
module hit_miss_thinning_pixel_core
   import hmt_pkg::*;
#(
   parameter int unsigned WINDOW_SIDE = WindowSide
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic [(WINDOW_SIDE+2)*(WINDOW_SIDE+2)-1:0]  req_window,
   input  logic [WINDOW_SIDE*WINDOW_SIDE-1:0]          req_outside_mask,
   output logic                                         rsp_valid,
   output logic                                         rsp_new_pixel,
   output logic                                         rsp_centre_marked,
   output logic                                         rsp_changed,
   input  logic                                         psel,
   input  logic                                         penable,
   input  logic                                         pwrite,
   input  logic [0:0]                                   paddr,
   input  logic [31:0]                                  pwdata,
   output logic [31:0]                                  prdata,
   output logic                                         pready
);

   localparam int unsigned FullSide  = WINDOW_SIDE + 2;
   localparam int unsigned Cells     = WINDOW_SIDE * WINDOW_SIDE;
   localparam int unsigned CentreBit = (FullSide / 2) * FullSide + FullSide / 2;
   localparam int unsigned CentrePos = (WINDOW_SIDE / 2) * WINDOW_SIDE + WINDOW_SIDE / 2;

   logic [1:0]                  mode_ff;
   logic                        in_valid_ff;
   logic [FullSide*FullSide-1:0] win_ff;
   logic [Cells-1:0]            out_ff;
   logic                        valid_ff;
   logic                        new_ff, mark_ff, chg_ff;
   logic [Cells-1:0]            marks;
   logic                        centre, cmark, hit, keep;
   logic                        csr_wr;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign prdata = (paddr == CSR_ADDR_MODE) ? {30'd0, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_SHRINK;
         in_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_wr && paddr == CSR_ADDR_MODE) mode_ff <= pwdata[1:0];
         in_valid_ff <= start;
         valid_ff    <= in_valid_ff;
      end
      win_ff  <= req_window;
      out_ff  <= req_outside_mask;
      new_ff  <= keep;
      mark_ff <= cmark;
      chg_ff  <= centre & ~keep;
   end

   always_comb begin
      cell_type n;
      n = '0;
      for (int pr = 0; pr < WINDOW_SIDE; pr++) begin
         for (int pc = 0; pc < WINDOW_SIDE; pc++) begin
            for (int k = 0; k < WINDOW_SIDE; k++)
               for (int l = 0; l < WINDOW_SIDE; l++)
                  n[k*WINDOW_SIDE+l] = win_ff[(pr+k)*FullSide + pc + l];
            marks[pr*WINDOW_SIDE+pc] = ~out_ff[pr*WINDOW_SIDE+pc] & cond_mark(n, mode_ff);
         end
      end
   end

   assign centre = win_ff[CentreBit];
   assign cmark  = marks[CentrePos];
   assign hit    = unc_hit(marks, mode_ff);
   assign keep   = centre & (~cmark | hit);

   assign rsp_valid         = valid_ff;
   assign rsp_new_pixel     = new_ff;
   assign rsp_centre_marked = mark_ff;
   assign rsp_changed       = chg_ff;

   `CHECK_IMPLY(a_lat, clock, reset, start |=> ##1 rsp_valid, "result missing")
   `CHECK_IMPLY(a_chg, clock, reset, rsp_changed |-> !rsp_new_pixel, "changed but kept")
   `CHECK_ALWAYS(a_busy, clock, !busy, "busy raised")

endmodule
